// ----- sv/htacc_pkg.sv -----
// Shared types, codes and constants of the homogeneous transform accumulator.
package htacc_pkg;

    localparam int ANG_BITS  = 30;
    localparam int TABLE_LEN = 24;
    localparam int ACC_W     = 67;

    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] GAIN_Q30    = 36'sd652032874;

    localparam logic [2:0] ACT_IDENTITY  = 3'd0;
    localparam logic [2:0] ACT_TRANSLATE = 3'd1;
    localparam logic [2:0] ACT_SCALE     = 3'd2;
    localparam logic [2:0] ACT_ROTATE    = 3'd3;
    localparam logic [2:0] ACT_SHEAR     = 3'd4;
    localparam logic [2:0] ACT_INVERT    = 3'd5;
    localparam logic [2:0] ACT_POINT     = 3'd6;
    localparam logic [2:0] ACT_RESERVED  = 3'd7;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_DIV_ZERO = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    // byte address of the mode register
    localparam logic [2:0] ADDR_MODE = 3'd0;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic neg;
    } mac_ctl_t;

    // arctan(2^-i) in Q2.30
    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0: v = 32'h3243F6A8;
            5'd1: v = 32'h1DAC6705;
            5'd2: v = 32'h0FADBAFC;
            5'd3: v = 32'h07F56EA6;
            5'd4: v = 32'h03FEAB77;
            5'd5: v = 32'h01FFD55B;
            5'd6: v = 32'h00FFFAAA;
            5'd7: v = 32'h007FFF55;
            5'd8: v = 32'h003FFFEA;
            5'd9: v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/htacc_mac.sv -----
// Pipelined multiply-accumulate with round-half-up and 32-bit saturation.
module htacc_mac #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  htacc_pkg::mac_ctl_t    ctl,
    input  logic signed [31:0]     op_a,
    input  logic signed [31:0]     op_b,
    output logic                   done,
    output logic signed [31:0]     result,
    output logic                   ovf
);
    localparam int AW = htacc_pkg::ACC_W;
    localparam logic signed [AW-1:0] SAT_HI = AW'(64'sd2147483647);
    localparam logic signed [AW-1:0] SAT_LO = AW'(-64'sd2147483648);
    localparam logic signed [AW-1:0] HALF   = AW'(64'sd1 <<< (FRAC_BITS - 1));

    logic signed [63:0]   prod;
    logic signed [63:0]   prod_reg;
    logic                 v1_reg;
    logic                 first1_reg;
    logic                 last1_reg;
    logic                 neg1_reg;
    logic signed [AW-1:0] acc_reg;
    logic                 done_reg;
    logic signed [AW-1:0] prod_ext;
    logic signed [AW-1:0] term;
    logic signed [AW-1:0] rnd_sum;
    logic signed [AW-1:0] rnd_shr;

    assign prod     = op_a * op_b;
    assign prod_ext = AW'(prod_reg);
    assign term     = neg1_reg ? -prod_ext : prod_ext;
    assign rnd_sum  = acc_reg + HALF;
    assign rnd_shr  = rnd_sum >>> FRAC_BITS;

    always_comb begin
        ovf    = 1'b0;
        result = rnd_shr[31:0];
        if (rnd_shr > SAT_HI) begin
            ovf    = 1'b1;
            result = 32'sh7FFFFFFF;
        end else if (rnd_shr < SAT_LO) begin
            ovf    = 1'b1;
            result = 32'sh80000000;
        end
    end

    assign done = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v1_reg   <= ctl.valid;
            done_reg <= v1_reg & last1_reg;
        end
        prod_reg   <= prod;
        first1_reg <= ctl.first;
        last1_reg  <= ctl.last;
        neg1_reg   <= ctl.neg;
        if (v1_reg) begin
            acc_reg <= (first1_reg ? '0 : acc_reg) + term;
        end
    end

endmodule

// ----- sv/htacc_div.sv -----
// Restoring divider for Q-format quotients, round to nearest, saturating.
module htacc_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [32:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [31:0] quo,
    output logic               dz,
    output logic               ovf
);
    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW);
    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_RUN  = 2'd1;
    localparam logic [1:0] D_SAT  = 2'd2;

    logic [1:0]        phase_reg;
    logic [NW-1:0]     dvd_reg;
    logic [31:0]       dsr_reg;
    logic [31:0]       rem_reg;
    logic [CW-1:0]     cnt_reg;
    logic              qneg_reg;
    logic              done_reg;
    logic signed [31:0] quo_reg;
    logic              dz_reg;
    logic              ovf_reg;
    logic [31:0]       abs_num;
    logic [31:0]       abs_den;
    logic [32:0]       rem_sh;
    logic              qbit;

    assign abs_num = num[32] ? 32'(-num) : num[31:0];
    assign abs_den = den[31] ? 32'(-den) : den;
    assign rem_sh  = {rem_reg, dvd_reg[NW-1]};
    assign qbit    = (rem_sh >= {1'b0, dsr_reg});

    assign done = done_reg;
    assign quo  = quo_reg;
    assign dz   = dz_reg;
    assign ovf  = ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (phase_reg)
                D_IDLE: begin
                    if (start) begin
                        if (den == 32'sd0) begin
                            done_reg <= 1'b1;
                            dz_reg   <= 1'b1;
                            ovf_reg  <= 1'b0;
                            quo_reg  <= num[32] ? 32'sh80000000 :
                                        ((num != 33'sd0) ? 32'sh7FFFFFFF : 32'sd0);
                        end else begin
                            dvd_reg   <= (NW'(abs_num) << FRAC_BITS) + NW'(abs_den >> 1);
                            dsr_reg   <= abs_den;
                            rem_reg   <= '0;
                            cnt_reg   <= CW'(NW - 1);
                            qneg_reg  <= num[32] ^ den[31];
                            phase_reg <= D_RUN;
                        end
                    end
                end
                D_RUN: begin
                    rem_reg <= qbit ? 32'(rem_sh - {1'b0, dsr_reg}) : rem_sh[31:0];
                    dvd_reg <= {dvd_reg[NW-2:0], qbit};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        phase_reg <= D_SAT;
                    end
                end
                D_SAT: begin
                    dz_reg   <= 1'b0;
                    ovf_reg  <= 1'b0;
                    done_reg <= 1'b1;
                    if (!qneg_reg) begin
                        if (dvd_reg > NW'(64'd2147483647)) begin
                            quo_reg <= 32'sh7FFFFFFF;
                            ovf_reg <= 1'b1;
                        end else begin
                            quo_reg <= dvd_reg[31:0];
                        end
                    end else begin
                        if (dvd_reg > NW'(64'd2147483648)) begin
                            quo_reg <= 32'sh80000000;
                            ovf_reg <= 1'b1;
                        end else begin
                            quo_reg <= -dvd_reg[31:0];
                        end
                    end
                    phase_reg <= D_IDLE;
                end
                default: phase_reg <= D_IDLE;
            endcase
        end
    end

endmodule

// ----- sv/htacc_cordic.sv -----
// Iterative sine/cosine: angle reduction by shift-subtract, then circular CORDIC.
module htacc_cordic #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] angle,
    output logic               done,
    output logic signed [31:0] sin_q,
    output logic signed [31:0] cos_q
);
    localparam int SH = htacc_pkg::ANG_BITS - FRAC_BITS;
    localparam int MW = 32 + SH;
    localparam int RW = 36;
    localparam int CW = $clog2(SH);
    localparam int IW = 5;
    localparam logic signed [RW-1:0] RND = RW'(64'sd1 <<< (SH - 1));

    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_MOD  = 3'd1;
    localparam logic [2:0] C_WRAP = 3'd2;
    localparam logic [2:0] C_FOLD = 3'd3;
    localparam logic [2:0] C_ROT  = 3'd4;
    localparam logic [2:0] C_OUT  = 3'd5;

    logic [2:0]           phase_reg;
    logic [MW-1:0]        mag_reg;
    logic [MW-1:0]        dsr_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 neg_reg;
    logic                 flip_reg;
    logic signed [RW-1:0] r_reg;
    logic signed [RW-1:0] x_reg;
    logic signed [RW-1:0] y_reg;
    logic [IW-1:0]        it_reg;
    logic                 done_reg;
    logic signed [31:0]   sin_reg;
    logic signed [31:0]   cos_reg;

    logic [31:0]          abs_angle;
    logic signed [RW-1:0] r0;
    logic signed [RW-1:0] atan_v;
    logic signed [RW-1:0] dx;
    logic signed [RW-1:0] dy;
    logic signed [RW-1:0] xr;
    logic signed [RW-1:0] yr;

    assign abs_angle = angle[31] ? 32'(-angle) : angle;
    assign r0     = neg_reg ? -$signed({2'b00, mag_reg[33:0]}) : $signed({2'b00, mag_reg[33:0]});
    assign atan_v = $signed({4'b0000, htacc_pkg::atan_q30(it_reg)});
    assign dx     = y_reg >>> it_reg;
    assign dy     = x_reg >>> it_reg;
    assign xr     = (x_reg + RND) >>> SH;
    assign yr     = (y_reg + RND) >>> SH;

    assign done  = done_reg;
    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (phase_reg)
                C_IDLE: begin
                    if (start) begin
                        mag_reg   <= {abs_angle, SH'(0)};
                        dsr_reg   <= MW'(htacc_pkg::TWO_PI_Q30) << (SH - 1);
                        cnt_reg   <= CW'(SH - 1);
                        neg_reg   <= angle[31];
                        phase_reg <= C_MOD;
                    end
                end
                C_MOD: begin
                    if (mag_reg >= dsr_reg) begin
                        mag_reg <= mag_reg - dsr_reg;
                    end
                    dsr_reg <= dsr_reg >> 1;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        phase_reg <= C_WRAP;
                    end
                end
                C_WRAP: begin
                    if (r0 > htacc_pkg::PI_Q30) begin
                        r_reg <= r0 - htacc_pkg::TWO_PI_Q30;
                    end else if (r0 < -htacc_pkg::PI_Q30) begin
                        r_reg <= r0 + htacc_pkg::TWO_PI_Q30;
                    end else begin
                        r_reg <= r0;
                    end
                    phase_reg <= C_FOLD;
                end
                C_FOLD: begin
                    // fold into the right half plane, negate the result later
                    if (r_reg > htacc_pkg::HALF_PI_Q30) begin
                        r_reg    <= r_reg - htacc_pkg::PI_Q30;
                        flip_reg <= 1'b1;
                    end else if (r_reg < -htacc_pkg::HALF_PI_Q30) begin
                        r_reg    <= r_reg + htacc_pkg::PI_Q30;
                        flip_reg <= 1'b1;
                    end else begin
                        flip_reg <= 1'b0;
                    end
                    x_reg     <= htacc_pkg::GAIN_Q30;
                    y_reg     <= '0;
                    it_reg    <= '0;
                    phase_reg <= C_ROT;
                end
                C_ROT: begin
                    if (r_reg >= 0) begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        r_reg <= r_reg - atan_v;
                    end else begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        r_reg <= r_reg + atan_v;
                    end
                    it_reg <= it_reg + 1'b1;
                    if (it_reg == IW'(CORDIC_STEPS - 1)) begin
                        phase_reg <= C_OUT;
                    end
                end
                C_OUT: begin
                    cos_reg   <= flip_reg ? -xr[31:0] : xr[31:0];
                    sin_reg   <= flip_reg ? -yr[31:0] : yr[31:0];
                    done_reg  <= 1'b1;
                    phase_reg <= C_IDLE;
                end
                default: phase_reg <= C_IDLE;
            endcase
        end
    end

endmodule

// ----- sv/homogeneous_transform_accumulator_core.sv -----
// Top level: transform matrix store, action sequencer and arithmetic units.
//
//  channel   ports                          transfer when
//  --------  -----------------------------  ----------------------------------
//  input     s_valid/s_ready, s_action..    s_valid & s_ready
//  result    m_valid/m_ready, m_out_x..     m_valid & m_ready
//  config    psel/penable/pwrite/paddr..    psel & penable & pwrite (pready=1)
//
// Work per item (n = 3 in 2D, 4 in 3D): a premultiply runs n*n dot products
// through the one multiply-accumulate unit; a rotation adds the CORDIC unit;
// shear adds two single-product passes; a shortcut inverse runs 4 or 6
// divisions; a point transform runs 3 dot products. Reset (aresetn low at a
// clock edge) loads identity, selects 2D mode and drops any pending result.
// A stalled result holds in the output register while the next item is
// already taken.
module homogeneous_transform_accumulator_core #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input items
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_action,
    input  logic signed [31:0] s_arg_a,
    input  logic signed [31:0] s_arg_b,
    input  logic signed [31:0] s_arg_c,
    input  logic signed [31:0] s_arg_d,
    input  logic [1:0]         s_axis,
    // results
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic signed [31:0] m_out_z,
    output logic [1:0]         m_status
);
    localparam logic signed [31:0] ONE_Q = 32'(64'sd1 <<< FRAC_BITS);
    localparam logic REG_IDX_MODE = 1'b0;

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_ROT_WAIT = 4'd2;
    localparam logic [3:0] S_ISSUE    = 4'd3;
    localparam logic [3:0] S_WAIT     = 4'd4;
    localparam logic [3:0] S_INV_RD   = 4'd5;
    localparam logic [3:0] S_INV_GO   = 4'd6;
    localparam logic [3:0] S_INV_WAIT = 4'd7;
    localparam logic [3:0] S_INV_SET  = 4'd8;
    localparam logic [3:0] S_FIN      = 4'd9;

    // what a running dot product feeds
    localparam logic [1:0] K_PREM  = 2'd0;
    localparam logic [1:0] K_SHEAR = 2'd1;
    localparam logic [1:0] K_POINT = 2'd2;

    logic [3:0]         state_reg;
    logic               mode_reg;
    logic signed [31:0] mat_reg [16];
    logic signed [31:0] nmat_reg [16];
    logic [2:0]         act_reg;
    logic signed [31:0] a_reg;
    logic signed [31:0] b_reg;
    logic signed [31:0] c_reg;
    logic signed [31:0] d_reg;
    logic [1:0]         axis_reg;
    logic [1:0]         kind_reg;
    logic [1:0]         row_reg;
    logic [1:0]         col_reg;
    logic [1:0]         k_reg;
    logic signed [31:0] colbuf_reg [4];
    logic signed [31:0] res_reg [3];
    logic signed [31:0] diag_reg;
    logic signed [31:0] inv_tr_reg [3];
    logic signed [31:0] inv_dg_reg [3];
    logic               ovf_reg;
    logic               dz_reg;
    logic               m_valid_reg;
    logic signed [31:0] out_x_reg;
    logic signed [31:0] out_y_reg;
    logic signed [31:0] out_z_reg;
    logic [1:0]         status_reg;

    logic               cfg_wr;
    logic [1:0]         t_idx;
    logic [1:0]         rows_last;
    logic [1:0]         dot_last;
    logic [1:0]         row_end;
    logic [1:0]         eff_axis;
    logic [1:0]         rot_p;
    logic [1:0]         rot_q;
    logic [3:0]         mat_rd_idx;
    logic signed [31:0] mat_rd;
    logic signed [31:0] vec_k;
    logic               out_free;

    htacc_pkg::mac_ctl_t mac_ctl;
    logic signed [31:0]  mac_a;
    logic signed [31:0]  mac_b;
    logic                mac_done;
    logic signed [31:0]  mac_res;
    logic                mac_ovf;

    logic                cor_start;
    logic                cor_done;
    logic signed [31:0]  cor_sin;
    logic signed [31:0]  cor_cos;

    logic                div_start;
    logic signed [32:0]  div_num;
    logic                div_done;
    logic signed [31:0]  div_quo;
    logic                div_dz;
    logic                div_ovf;

    // configuration port: one register, no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_IDX_MODE);
    assign prdata = (paddr[2] == REG_IDX_MODE) ? {31'd0, mode_reg} : 32'd0;

    // last row/column index of the active block doubles as the translation column
    assign t_idx     = mode_reg ? 2'd3 : 2'd2;
    assign rows_last = mode_reg ? 2'd2 : 2'd1;
    assign dot_last  = (kind_reg == K_SHEAR) ? 2'd0 : t_idx;
    assign eff_axis  = mode_reg ? axis_reg : htacc_pkg::AXIS_Z;

    always_comb begin
        case (kind_reg)
            K_SHEAR: row_end = 2'd1;
            K_POINT: row_end = 2'd2;
            default: row_end = t_idx;
        endcase
    end

    // rotation plane for the selected axis
    always_comb begin
        case (eff_axis)
            htacc_pkg::AXIS_X: begin
                rot_p = 2'd1;
                rot_q = 2'd2;
            end
            htacc_pkg::AXIS_Y: begin
                rot_p = 2'd0;
                rot_q = 2'd2;
            end
            default: begin
                rot_p = 2'd0;
                rot_q = 2'd1;
            end
        endcase
    end

    // single read port on the matrix store
    always_comb begin
        case (state_reg)
            S_INV_RD: mat_rd_idx = {row_reg, row_reg};
            S_INV_GO: mat_rd_idx = {row_reg, t_idx};
            default:  mat_rd_idx = (kind_reg == K_PREM) ? {k_reg, col_reg} : {row_reg, k_reg};
        endcase
    end
    assign mat_rd = mat_reg[mat_rd_idx];

    // homogeneous point vector, w = 1.0
    always_comb begin
        case (k_reg)
            2'd0:    vec_k = a_reg;
            2'd1:    vec_k = b_reg;
            2'd2:    vec_k = mode_reg ? c_reg : ONE_Q;
            default: vec_k = ONE_Q;
        endcase
    end

    // operand select for the multiply-accumulate unit
    always_comb begin
        case (kind_reg)
            K_SHEAR: begin
                mac_a = (row_reg == 2'd0) ? a_reg : b_reg;
                mac_b = (row_reg == 2'd0) ? d_reg : c_reg;
            end
            K_POINT: begin
                mac_a = mat_rd;
                mac_b = vec_k;
            end
            default: begin
                mac_a = nmat_reg[{row_reg, k_reg}];
                mac_b = mat_rd;
            end
        endcase
        mac_ctl.valid = (state_reg == S_ISSUE);
        mac_ctl.first = (k_reg == 2'd0);
        mac_ctl.last  = (k_reg == dot_last);
        mac_ctl.neg   = (kind_reg == K_SHEAR);
    end

    assign cor_start = (state_reg == S_DISPATCH) && (act_reg == htacc_pkg::ACT_ROTATE) &&
                       (eff_axis != htacc_pkg::AXIS_NONE);
    assign div_start = (state_reg == S_INV_GO);
    assign div_num   = (k_reg == 2'd0) ? -{mat_rd[31], mat_rd} : 33'(ONE_Q);

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    assign m_valid  = m_valid_reg;
    assign m_out_x  = out_x_reg;
    assign m_out_y  = out_y_reg;
    assign m_out_z  = out_z_reg;
    assign m_status = status_reg;

    htacc_mac #(
        .FRAC_BITS(FRAC_BITS)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .op_a    (mac_a),
        .op_b    (mac_b),
        .done    (mac_done),
        .result  (mac_res),
        .ovf     (mac_ovf)
    );

    htacc_cordic #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .angle   (a_reg),
        .done    (cor_done),
        .sin_q   (cor_sin),
        .cos_q   (cor_cos)
    );

    htacc_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (diag_reg),
        .done    (div_done),
        .quo     (div_quo),
        .dz      (div_dz),
        .ovf     (div_ovf)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            mode_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            ovf_reg     <= 1'b0;
            dz_reg      <= 1'b0;
            for (int i = 0; i < 16; i++) begin
                mat_reg[i] <= (i % 5 == 0) ? ONE_Q : 32'sd0;
            end
        end else begin
            // drop the result once it is taken
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // a mode write reloads identity
            if (cfg_wr) begin
                mode_reg <= pwdata[0];
                for (int i = 0; i < 16; i++) begin
                    mat_reg[i] <= (i % 5 == 0) ? ONE_Q : 32'sd0;
                end
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        act_reg   <= s_action;
                        a_reg     <= s_arg_a;
                        b_reg     <= s_arg_b;
                        c_reg     <= s_arg_c;
                        d_reg     <= s_arg_d;
                        axis_reg  <= s_axis;
                        ovf_reg   <= 1'b0;
                        dz_reg    <= 1'b0;
                        for (int i = 0; i < 3; i++) begin
                            res_reg[i] <= 32'sd0;
                        end
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    // build the elementary matrix over identity
                    for (int i = 0; i < 16; i++) begin
                        nmat_reg[i] <= (i % 5 == 0) ? ONE_Q : 32'sd0;
                    end
                    row_reg  <= 2'd0;
                    col_reg  <= 2'd0;
                    k_reg    <= 2'd0;
                    kind_reg <= K_PREM;
                    case (act_reg)
                        htacc_pkg::ACT_IDENTITY: begin
                            for (int i = 0; i < 16; i++) begin
                                mat_reg[i] <= (i % 5 == 0) ? ONE_Q : 32'sd0;
                            end
                            state_reg <= S_FIN;
                        end
                        htacc_pkg::ACT_TRANSLATE: begin
                            nmat_reg[{2'd0, t_idx}] <= a_reg;
                            nmat_reg[{2'd1, t_idx}] <= b_reg;
                            if (mode_reg) begin
                                nmat_reg[{2'd2, t_idx}] <= c_reg;
                            end
                            state_reg <= S_ISSUE;
                        end
                        htacc_pkg::ACT_SCALE: begin
                            nmat_reg[0] <= a_reg;
                            nmat_reg[5] <= b_reg;
                            if (mode_reg) begin
                                nmat_reg[10] <= c_reg;
                            end
                            state_reg <= S_ISSUE;
                        end
                        htacc_pkg::ACT_ROTATE: begin
                            state_reg <= (eff_axis == htacc_pkg::AXIS_NONE) ? S_FIN : S_ROT_WAIT;
                        end
                        htacc_pkg::ACT_SHEAR: begin
                            nmat_reg[1] <= a_reg;
                            nmat_reg[4] <= b_reg;
                            kind_reg    <= K_SHEAR;
                            state_reg   <= S_ISSUE;
                        end
                        htacc_pkg::ACT_INVERT: begin
                            state_reg <= S_INV_RD;
                        end
                        htacc_pkg::ACT_POINT: begin
                            kind_reg  <= K_POINT;
                            state_reg <= S_ISSUE;
                        end
                        default: state_reg <= S_FIN;
                    endcase
                end
                S_ROT_WAIT: begin
                    if (cor_done) begin
                        nmat_reg[{rot_p, rot_p}] <= cor_cos;
                        nmat_reg[{rot_p, rot_q}] <= -cor_sin;
                        nmat_reg[{rot_q, rot_p}] <= cor_sin;
                        nmat_reg[{rot_q, rot_q}] <= cor_cos;
                        state_reg <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    // one product per cycle into the accumulator
                    if (k_reg == dot_last) begin
                        k_reg     <= 2'd0;
                        state_reg <= S_WAIT;
                    end else begin
                        k_reg <= k_reg + 2'd1;
                    end
                end
                S_WAIT: begin
                    if (mac_done) begin
                        ovf_reg   <= ovf_reg | mac_ovf;
                        state_reg <= S_ISSUE;
                        row_reg   <= (row_reg == row_end) ? 2'd0 : row_reg + 2'd1;
                        case (kind_reg)
                            K_SHEAR: begin
                                nmat_reg[{row_reg, t_idx}] <= mac_res;
                                if (row_reg == row_end) begin
                                    kind_reg <= K_PREM;
                                end
                            end
                            K_POINT: begin
                                res_reg[row_reg] <= mac_res;
                                if (row_reg == row_end) begin
                                    state_reg <= S_FIN;
                                end
                            end
                            default: begin
                                colbuf_reg[row_reg] <= mac_res;
                                if (row_reg == row_end) begin
                                    // column done: write it back, later columns
                                    // never read this one
                                    for (int i = 0; i < 4; i++) begin
                                        if (2'(i) <= t_idx) begin
                                            mat_reg[{2'(i), col_reg}] <=
                                                (2'(i) == row_reg) ? mac_res : colbuf_reg[i];
                                        end
                                    end
                                    if (col_reg == t_idx) begin
                                        state_reg <= S_FIN;
                                    end else begin
                                        col_reg <= col_reg + 2'd1;
                                    end
                                end
                            end
                        endcase
                    end
                end
                S_INV_RD: begin
                    diag_reg  <= mat_rd;
                    k_reg     <= 2'd0;
                    state_reg <= S_INV_GO;
                end
                S_INV_GO: begin
                    state_reg <= S_INV_WAIT;
                end
                S_INV_WAIT: begin
                    if (div_done) begin
                        dz_reg  <= dz_reg | div_dz;
                        ovf_reg <= ovf_reg | div_ovf;
                        if (k_reg == 2'd0) begin
                            inv_tr_reg[row_reg] <= div_quo;
                            k_reg               <= 2'd1;
                            state_reg           <= S_INV_GO;
                        end else begin
                            inv_dg_reg[row_reg] <= div_quo;
                            k_reg               <= 2'd0;
                            if (row_reg == rows_last) begin
                                state_reg <= S_INV_SET;
                            end else begin
                                row_reg   <= row_reg + 2'd1;
                                state_reg <= S_INV_RD;
                            end
                        end
                    end
                end
                S_INV_SET: begin
                    // replace M: identity plus scale diagonal and translation
                    for (int i = 0; i < 16; i++) begin
                        mat_reg[i] <= (i % 5 == 0) ? ONE_Q : 32'sd0;
                    end
                    for (int i = 0; i < 3; i++) begin
                        if (2'(i) <= rows_last) begin
                            mat_reg[{2'(i), 2'(i)}] <= inv_dg_reg[i];
                            mat_reg[{2'(i), t_idx}] <= inv_tr_reg[i];
                        end
                    end
                    row_reg   <= 2'd0;
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (out_free) begin
                        out_x_reg   <= res_reg[0];
                        out_y_reg   <= res_reg[1];
                        out_z_reg   <= res_reg[2];
                        status_reg  <= dz_reg ? htacc_pkg::STAT_DIV_ZERO :
                                       (ovf_reg ? htacc_pkg::STAT_OVERFLOW : htacc_pkg::STAT_OK);
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_mac_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done |-> (state_reg == S_WAIT))
        else $error("accumulator finished outside a dot-product wait");

    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_INV_WAIT))
        else $error("divider finished outside an inverse wait");

    a_cordic_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        cor_done |-> (state_reg == S_ROT_WAIT))
        else $error("CORDIC finished outside a rotation wait");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == htacc_pkg::STAT_OK || m_status == htacc_pkg::STAT_DIV_ZERO ||
                     m_status == htacc_pkg::STAT_OVERFLOW))
        else $error("result carries an undefined status code");
`endif

endmodule

// ----- tb/htacc_checker.sv -----
// Result checker: tracks the transform matrix and compares every result transfer.
module htacc_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [2:0]         s_action,
    input  logic signed [31:0] s_arg_a,
    input  logic signed [31:0] s_arg_b,
    input  logic signed [31:0] s_arg_c,
    input  logic signed [31:0] s_arg_d,
    input  logic [1:0]         s_axis,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_out_x,
    input  logic signed [31:0] m_out_y,
    input  logic signed [31:0] m_out_z,
    input  logic [1:0]         m_status,
    output int                 fail_count,
    output int                 pending,
    output int                 checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     FRAC    = 16;
    localparam int     STEPS   = 16;
    localparam int     ASH     = htacc_pkg::ANG_BITS - FRAC;
    localparam longint ONE     = 64'sd1 <<< FRAC;
    localparam longint MAX32   = 64'sd2147483647;
    localparam longint MIN32   = -64'sd2147483648;
    localparam longint PI_L      = longint'(htacc_pkg::PI_Q30);
    localparam longint TWO_PI_L  = longint'(htacc_pkg::TWO_PI_Q30);
    localparam longint HALF_PI_L = longint'(htacc_pkg::HALF_PI_Q30);
    localparam longint GAIN_L    = longint'(htacc_pkg::GAIN_Q30);

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [1:0]         status;
    } point_result_t;

    longint        matrix[16];
    bit            mode_3d;
    point_result_t result_queue[$];
    longint        arctan_tbl[STEPS];

    initial begin
        arctan_tbl = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                       64'h03FEAB77, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                       64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                       64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};
        fail_count = 0;
        checked    = 0;
    end

    assign pending = result_queue.size();

    function automatic void set_identity(ref longint m[16]);
        for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? ONE : 0;
    endfunction

    function automatic longint clip32(longint v, inout bit ovf);
        if (v > MAX32) begin
            ovf = 1;
            return MAX32;
        end
        if (v < MIN32) begin
            ovf = 1;
            return MIN32;
        end
        return v;
    endfunction

    // exact sum of products, one rounding (half up), then clip
    function automatic longint dot_q(longint a[4], longint b[4], int n, inout bit ovf);
        longint hi_sum, lo_sum, p, hi;
        hi_sum = 0;
        lo_sum = 0;
        for (int k = 0; k < n; k++) begin
            p = a[k] * b[k];
            hi = p >>> FRAC;
            hi_sum += hi;
            lo_sum += p - hi * ONE;
        end
        hi_sum += (lo_sum + (ONE >>> 1)) >>> FRAC;
        return clip32(hi_sum, ovf);
    endfunction

    function automatic longint div_q(longint num, longint den, inout bit dz, inout bit ovf);
        longint unsigned un, ud, q;
        longint v;
        if (den == 0) begin
            dz = 1;
            return (num > 0) ? MAX32 : ((num < 0) ? MIN32 : 0);
        end
        un = longint'(num < 0 ? -num : num) << FRAC;
        ud = longint'(den < 0 ? -den : den);
        q  = (un + ud / 2) / ud;
        v  = ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
        return clip32(v, ovf);
    endfunction

    function automatic void cordic_sincos(longint angle, output longint s, output longint c);
        longint r, x, y, dx, dy;
        bit flip;
        r = (angle * (64'sd1 <<< ASH)) % TWO_PI_L;
        x = GAIN_L;
        y = 0;
        flip = 0;
        if (r > PI_L) r -= TWO_PI_L;
        if (r < -PI_L) r += TWO_PI_L;
        if (r > HALF_PI_L) begin
            r -= PI_L;
            flip = 1;
        end else if (r < -HALF_PI_L) begin
            r += PI_L;
            flip = 1;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (r >= 0) begin
                x -= dx; y += dy; r -= arctan_tbl[i];
            end else begin
                x += dx; y -= dy; r += arctan_tbl[i];
            end
        end
        x = (x + (64'sd1 <<< (ASH - 1))) >>> ASH;
        y = (y + (64'sd1 <<< (ASH - 1))) >>> ASH;
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic void premultiply(longint nm[16], int n, inout bit ovf);
        longint prod[16];
        longint a[4], b[4];
        prod = matrix;
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++) begin
                a = '{0, 0, 0, 0};
                b = '{0, 0, 0, 0};
                for (int k = 0; k < n; k++) begin
                    a[k] = nm[r * 4 + k];
                    b[k] = matrix[k * 4 + c];
                end
                prod[r * 4 + c] = dot_q(a, b, n, ovf);
            end
        matrix = prod;
    endfunction

    // update the matrix for one action and return the result it produces
    function automatic point_result_t apply_action(logic [2:0] act, longint a, longint b,
                                                   longint c, longint d, logic [1:0] ax);
        point_result_t res;
        longint nm[16];
        longint s, co, diag, tr;
        longint u[4], v[4], row[4];
        longint out3[3];
        int n, t, p, q, rows;
        bit ovf, dz;
        n = mode_3d ? 4 : 3;
        t = n - 1;
        ovf = 0;
        dz = 0;
        out3 = '{0, 0, 0};
        set_identity(nm);
        case (act)
            htacc_pkg::ACT_IDENTITY: set_identity(matrix);
            htacc_pkg::ACT_TRANSLATE: begin
                nm[t] = a;
                nm[4 + t] = b;
                if (n == 4) nm[8 + t] = c;
                premultiply(nm, n, ovf);
            end
            htacc_pkg::ACT_SCALE: begin
                nm[0] = a;
                nm[5] = b;
                if (n == 4) nm[10] = c;
                premultiply(nm, n, ovf);
            end
            htacc_pkg::ACT_ROTATE: begin
                if (n == 3) ax = htacc_pkg::AXIS_Z;
                if (ax != htacc_pkg::AXIS_NONE) begin
                    p = (ax == htacc_pkg::AXIS_X) ? 1 : 0;
                    q = (ax == htacc_pkg::AXIS_Z) ? 1 : 2;
                    cordic_sincos(a, s, co);
                    nm[p * 4 + p] = co;
                    nm[p * 4 + q] = -s;
                    nm[q * 4 + p] = s;
                    nm[q * 4 + q] = co;
                    premultiply(nm, n, ovf);
                end
            end
            htacc_pkg::ACT_SHEAR: begin
                nm[1] = a;
                nm[4] = b;
                u = '{-a, 0, 0, 0};
                v = '{d, 0, 0, 0};
                nm[t] = dot_q(u, v, 1, ovf);
                u = '{-b, 0, 0, 0};
                v = '{c, 0, 0, 0};
                nm[4 + t] = dot_q(u, v, 1, ovf);
                premultiply(nm, n, ovf);
            end
            htacc_pkg::ACT_INVERT: begin
                rows = (n == 4) ? 3 : 2;
                for (int i = 0; i < rows; i++) begin
                    diag = matrix[i * 5];
                    tr = matrix[i * 4 + t];
                    nm[i * 5] = div_q(ONE, diag, dz, ovf);
                    nm[i * 4 + t] = div_q(-tr, diag, dz, ovf);
                end
                matrix = nm;
            end
            htacc_pkg::ACT_POINT: begin
                v = '{a, b, 0, 0};
                if (n == 4) begin
                    v[2] = c;
                    v[3] = ONE;
                end else begin
                    v[2] = ONE;
                end
                for (int i = 0; i < 3; i++) begin
                    row = '{0, 0, 0, 0};
                    for (int k = 0; k < n; k++) row[k] = matrix[i * 4 + k];
                    out3[i] = dot_q(row, v, n, ovf);
                end
            end
            default: ;
        endcase
        res.x = out3[0][31:0];
        res.y = out3[1][31:0];
        res.z = out3[2][31:0];
        res.status = dz ? htacc_pkg::STAT_DIV_ZERO :
                     (ovf ? htacc_pkg::STAT_OVERFLOW : htacc_pkg::STAT_OK);
        return res;
    endfunction

    task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got %h, want %h", $realtime, field, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        point_result_t want;
        if (!aresetn) begin
            mode_3d = 0;
            set_identity(matrix);
            result_queue.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (result_queue.size() == 0) begin
                    flag_mismatch("unexpected result", m_out_x, 32'h0);
                end else begin
                    want = result_queue.pop_front();
                    checked++;
                    if (m_out_x !== want.x) flag_mismatch("out_x", m_out_x, want.x);
                    if (m_out_y !== want.y) flag_mismatch("out_y", m_out_y, want.y);
                    if (m_out_z !== want.z) flag_mismatch("out_z", m_out_z, want.z);
                    if (m_status !== want.status)
                        flag_mismatch("status", m_status, want.status);
                end
            end
            if (psel && penable && pwrite && pready && paddr == htacc_pkg::ADDR_MODE) begin
                mode_3d = pwdata[0];
                set_identity(matrix);
            end
            if (s_valid && s_ready)
                result_queue.push_back(apply_action(s_action, s_arg_a, s_arg_b, s_arg_c,
                                                    s_arg_d, s_axis));
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top: clock, reset, stimulus and verdict for the transform accumulator.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int RAND_ITEMS  = 250;   // per random phase, three phases
    localparam logic signed [31:0] Q_ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] Q_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] HALF_PI = 32'sd102944;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               psel = 0, penable = 0, pwrite = 0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 0;
    logic               s_ready;
    logic [2:0]         s_action = htacc_pkg::ACT_IDENTITY;
    logic signed [31:0] s_arg_a = '0, s_arg_b = '0, s_arg_c = '0, s_arg_d = '0;
    logic [1:0]         s_axis = htacc_pkg::AXIS_X;
    logic               m_valid;
    logic               m_ready = 0;
    logic signed [31:0] m_out_x, m_out_y, m_out_z;
    logic [1:0]         m_status;

    int fail_count, pending, checked;
    int tx_idle_pct = 0, rx_idle_pct = 0;
    int items_sent = 0;
    int cycles = 0;

    always #6 aclk = ~aclk;

    homogeneous_transform_accumulator_core i_dut (.*);

    htacc_checker i_checker (.*);

    // Receiver: drop ready at random, per the current idle rate.
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Watchdog: end the run if the block stops making progress.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("homogeneous_transform_accumulator_core test failed");
            $finish;
        end
    end

    // Present one item and hold it until the transfer. Called at a rising edge;
    // returns at the edge of the transfer, with valid still high.
    task automatic send_action(logic [2:0] act, logic signed [31:0] a, logic signed [31:0] b,
                               logic signed [31:0] c, logic signed [31:0] d, logic [1:0] ax);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < tx_idle_pct) @(posedge aclk);
        end
        s_action <= act;
        s_arg_a  <= a;
        s_arg_b  <= b;
        s_arg_c  <= c;
        s_arg_d  <= d;
        s_axis   <= ax;
        s_valid  <= 1'b1;
        // sample ready mid-cycle, away from the edge where it may change
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        items_sent++;
    endtask

    // Drain outstanding results, then write the mode register over APB.
    task automatic write_mode(logic mode);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= htacc_pkg::ADDR_MODE;
        pwdata  <= {31'd0, mode};
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Q16.16 operand: mostly modest values so matrices stay meaningful,
    // with some unity, zero and full-range values mixed in.
    function automatic logic signed [31:0] pick_q();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
        if (sel < 70) return Q_ONE + $signed($urandom_range(0, 4095)) - 2048;
        if (sel < 78) return -Q_ONE;
        if (sel < 85) return '0;
        return $urandom;
    endfunction

    task automatic send_random();
        int sel;
        logic [2:0] act;
        sel = $urandom_range(0, 99);
        if      (sel < 4)  act = htacc_pkg::ACT_IDENTITY;
        else if (sel < 20) act = htacc_pkg::ACT_TRANSLATE;
        else if (sel < 32) act = htacc_pkg::ACT_SCALE;
        else if (sel < 52) act = htacc_pkg::ACT_ROTATE;
        else if (sel < 62) act = htacc_pkg::ACT_SHEAR;
        else if (sel < 70) act = htacc_pkg::ACT_INVERT;
        else if (sel < 98) act = htacc_pkg::ACT_POINT;
        else               act = htacc_pkg::ACT_RESERVED;
        send_action(act, pick_q(), pick_q(), pick_q(), pick_q(), 2'($urandom_range(0, 3)));
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, 2D after reset: extremes, every action, divide by zero.
        send_action(htacc_pkg::ACT_POINT, Q_ONE, 2 * Q_ONE, 0, 0, htacc_pkg::AXIS_X);
        send_action(htacc_pkg::ACT_TRANSLATE, Q_MAX, Q_MIN, Q_MAX, 0, htacc_pkg::AXIS_X);
        send_action(htacc_pkg::ACT_POINT, Q_MAX, Q_MIN, Q_MIN, Q_MAX, htacc_pkg::AXIS_Z);
        send_action(htacc_pkg::ACT_SCALE, 0, 3 * Q_ONE, 0, 0, htacc_pkg::AXIS_X);
        send_action(htacc_pkg::ACT_INVERT, 0, 0, 0, 0, htacc_pkg::AXIS_X);
        send_action(htacc_pkg::ACT_IDENTITY, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                    htacc_pkg::AXIS_NONE);
        send_action(htacc_pkg::ACT_ROTATE, HALF_PI, 0, 0, 0, htacc_pkg::AXIS_NONE);
        send_action(htacc_pkg::ACT_ROTATE, Q_MIN, 0, 0, 0, htacc_pkg::AXIS_X);
        send_action(htacc_pkg::ACT_SHEAR, Q_ONE / 2, -Q_ONE, 5 * Q_ONE, -3 * Q_ONE,
                    htacc_pkg::AXIS_X);
        send_action(htacc_pkg::ACT_INVERT, 0, 0, 0, 0, htacc_pkg::AXIS_X);
        send_action(htacc_pkg::ACT_POINT, -Q_ONE, Q_ONE, 0, 0, htacc_pkg::AXIS_X);
        send_action(htacc_pkg::ACT_RESERVED, Q_MIN, Q_MIN, Q_MIN, Q_MIN, htacc_pkg::AXIS_Z);

        // Directed, 3D: every axis, including the one with no meaning.
        write_mode(1'b1);
        send_action(htacc_pkg::ACT_TRANSLATE, Q_ONE, -2 * Q_ONE, 7 * Q_ONE, 0,
                    htacc_pkg::AXIS_X);
        send_action(htacc_pkg::ACT_ROTATE, HALF_PI, 0, 0, 0, htacc_pkg::AXIS_X);
        send_action(htacc_pkg::ACT_ROTATE, -HALF_PI, 0, 0, 0, htacc_pkg::AXIS_Y);
        send_action(htacc_pkg::ACT_ROTATE, Q_MAX, 0, 0, 0, htacc_pkg::AXIS_Z);
        send_action(htacc_pkg::ACT_ROTATE, Q_ONE, 0, 0, 0, htacc_pkg::AXIS_NONE);
        send_action(htacc_pkg::ACT_SCALE, 2 * Q_ONE, Q_ONE / 4, -Q_ONE, 0, htacc_pkg::AXIS_X);
        send_action(htacc_pkg::ACT_SHEAR, Q_MAX, Q_MIN, Q_MAX, Q_MIN, htacc_pkg::AXIS_X);
        send_action(htacc_pkg::ACT_POINT, Q_ONE, Q_ONE, Q_ONE, 0, htacc_pkg::AXIS_X);
        send_action(htacc_pkg::ACT_IDENTITY, 0, 0, 0, 0, htacc_pkg::AXIS_X);
        send_action(htacc_pkg::ACT_SCALE, Q_ONE, 0, 2 * Q_ONE, 0, htacc_pkg::AXIS_X);
        send_action(htacc_pkg::ACT_INVERT, 0, 0, 0, 0, htacc_pkg::AXIS_X);
        send_action(htacc_pkg::ACT_POINT, Q_MIN, Q_MAX, Q_MIN, 0, htacc_pkg::AXIS_X);

        // Random phases: receiver-heavy idling, sender-heavy idling, then none.
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 31 : ((ph == 1) ? 76 : 0);
            rx_idle_pct = (ph == 0) ? 76 : ((ph == 1) ? 31 : 0);
            write_mode(ph[0]);
            for (int i = 0; i < RAND_ITEMS; i++) send_random();
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);

        $display("sent %0d actions over 2D and 3D modes, %0d results checked",
                 items_sent, checked);
        if (fail_count == 0) begin
            $display("homogeneous_transform_accumulator_core test passed");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("homogeneous_transform_accumulator_core test failed");
        end
        $finish;
    end

endmodule
